FILE: rtl/core/midpoint_ellipse_rasterizer_top_defines.svh
// Assertion macros for the midpoint ellipse rasterizer.
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_TOP_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define MER_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause.
`define MER_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/mer_pkg.sv
// Shared types and constants of the midpoint ellipse rasterizer.
package mer_pkg;

	// Fixed field widths
	localparam int CENTER_W = 11;
	localparam int AXIS_W   = 10;
	localparam int PIX_W    = 13;

	// Parameter defaults
	localparam int SCREEN_W_DEF  = 800;
	localparam int SCREEN_H_DEF  = 600;
	localparam int AXIS_BITS_DEF = 10;

	// Request operation codes
	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// Sequencer step counts (index of the final step)
	localparam int CNT_W      = 3;
	localparam int START_LAST = 3;
	localparam int XOVER_LAST = 5;
	localparam int EMIT_LAST  = 3;

	typedef enum logic [2:0] {
		ST_READY,
		ST_START,
		ST_XOVER,
		ST_UPDATE,
		ST_EMIT
	} ctl_state_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_R1,
		PH_R2
	} phase_t;

	// Multiplier operand pairs
	typedef enum logic [2:0] {
		MS_AA,    // a * a
		MS_BB,    // b * b
		MS_A2Y,   // a^2 * b
		MS_TT,    // (2x+1)^2
		MS_B2P,   // b^2 * previous product
		MS_UU,    // (y-1)^2
		MS_A2P,   // a^2 * previous product
		MS_A2B2   // a^2 * b^2
	} mul_sel_t;

	typedef struct packed {
		logic     load_start;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     ld_a2;
		logic     ld_b2;
		logic     init_fin;
		logic     acc_ld;
		logic     acc_add;
		logic     xover_fin;
		logic     update;
		logic     region2;
		logic     done;
		logic     emit_ld;
		logic [1:0] emit_idx;
	} dp_cmd_t;

	typedef struct packed {
		logic dx_lt_dy;
		logic y_zero;
		logic y_neg;
		logic out_free;
	} dp_sts_t;

endpackage

FILE: rtl/core/mer_if.sv
// Request and point channel interfaces of the midpoint ellipse rasterizer.
interface mer_in_if;
	logic valid;
	logic ready;
	logic operation;
	logic signed [mer_pkg::CENTER_W-1:0] center_x;
	logic signed [mer_pkg::CENTER_W-1:0] center_y;
	logic [mer_pkg::AXIS_W-1:0] axis_x;
	logic [mer_pkg::AXIS_W-1:0] axis_y;

	modport source (output valid, operation, center_x, center_y, axis_x, axis_y,
		input ready);
	modport sink (input valid, operation, center_x, center_y, axis_x, axis_y,
		output ready);
endinterface

interface mer_out_if;
	logic valid;
	logic ready;
	logic signed [mer_pkg::PIX_W-1:0] pixel_x;
	logic signed [mer_pkg::PIX_W-1:0] pixel_y;
	logic last_of_step;
	logic ellipse_done;

	modport source (output valid, pixel_x, pixel_y, last_of_step, ellipse_done,
		input ready);
	modport sink (input valid, pixel_x, pixel_y, last_of_step, ellipse_done,
		output ready);
endinterface

FILE: rtl/core/midpoint_ellipse_rasterizer_top.sv
// Top level of the midpoint ellipse rasterizer.
// Midpoint ellipse rasterizer. A start request (operation 0) loads the center and the
// semi-axes a and b and sets up the region-1 decision; it runs the accept and then four
// setup steps, in which the one shared multiplier forms a^2, b^2 and a^2*b.
// Each step request (operation 1) yields four points (+x,+y), (-x,+y), (+x,-y), (-x,-y)
// in screen coordinates, the fourth flagged last_of_step, all four flagged ellipse_done
// on the final step. An emitting step runs the accept, an update state and four loads
// that put the points one by one into the single output register, so a slow sink
// stalls the loads. The step at the region crossover first runs a crossover sequence
// in which the shared multiplier forms the region-2 decision as a chain of products. A step
// while no ellipse is active yields nothing. Decisions are exact integers scaled by 4;
// coordinates wrap to 13 bits.
`include "midpoint_ellipse_rasterizer_top_defines.svh"

module midpoint_ellipse_rasterizer_top #(
	parameter int SCREEN_W  = mer_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H  = mer_pkg::SCREEN_H_DEF,
	parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	mer_in_if.sink     request,
	mer_out_if.source  point
);

	mer_pkg::dp_cmd_t ctl_cmd;
	mer_pkg::dp_sts_t dp_sts;
	logic in_ready;
	logic start_accept;

	mer_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_op    (request.operation),
		.in_ready (in_ready),
		.cmd      (ctl_cmd),
		.sts      (dp_sts)
	);

	mer_dp #(
		.SCREEN_W  (SCREEN_W),
		.SCREEN_H  (SCREEN_H),
		.AXIS_BITS (AXIS_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.center_x     (request.center_x),
		.center_y     (request.center_y),
		.axis_x       (request.axis_x),
		.axis_y       (request.axis_y),
		.cmd          (ctl_cmd),
		.sts          (dp_sts),
		.out_valid    (point.valid),
		.out_ready    (point.ready),
		.pixel_x      (point.pixel_x),
		.pixel_y      (point.pixel_y),
		.last_of_step (point.last_of_step),
		.ellipse_done (point.ellipse_done)
	);

	assign request.ready = in_ready;

	// Flag an accepted start request
	assign start_accept = request.valid && request.ready &&
		(request.operation == mer_pkg::OP_START);

	// Never overwrite a point that the sink has not taken
	`MER_ASSERT_SAME(a_emit_slot, ctl_cmd.emit_ld, dp_sts.out_free, "point loaded over an untaken point")
	// A start request always runs the setup sequence
	`MER_ASSERT_NEXT(a_start_busy, start_accept, !request.ready, "start request skipped the setup")
	// An update is always followed by point output
	`MER_ASSERT_NEXT(a_update_emit, ctl_cmd.update, !request.ready, "update not followed by point output")

endmodule

FILE: rtl/core/mer_ctrl.sv
// Controller of the midpoint ellipse rasterizer: sequences setup, crossover and point output.
module mer_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_op,
	output logic              in_ready,
	output mer_pkg::dp_cmd_t  cmd,
	input  mer_pkg::dp_sts_t  sts
);

	mer_pkg::ctl_state_t state_q, state_d;
	mer_pkg::phase_t     phase_q, phase_d;
	logic [mer_pkg::CNT_W-1:0] cnt_q, cnt_d;
	logic accept;

	assign accept = in_valid && (state_q == mer_pkg::ST_READY);

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mer_pkg::ST_READY;
			phase_q <= mer_pkg::PH_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
		end
	end

	// Next state, phase and step count
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cnt_d   = cnt_q;
		unique case (state_q)
			mer_pkg::ST_READY: begin
				if (accept) begin
					if (in_op == mer_pkg::OP_START) begin
						state_d = mer_pkg::ST_START;
						phase_d = mer_pkg::PH_R1;
						cnt_d   = '0;
					end else if (phase_q == mer_pkg::PH_R1 && !sts.dx_lt_dy) begin
						state_d = mer_pkg::ST_XOVER;
						cnt_d   = '0;
					end else if (phase_q != mer_pkg::PH_IDLE) begin
						state_d = mer_pkg::ST_UPDATE;
					end
				end
			end
			mer_pkg::ST_START: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == mer_pkg::CNT_W'(mer_pkg::START_LAST)) begin
					state_d = mer_pkg::ST_READY;
				end
			end
			mer_pkg::ST_XOVER: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == mer_pkg::CNT_W'(mer_pkg::XOVER_LAST)) begin
					phase_d = mer_pkg::PH_R2;
					state_d = mer_pkg::ST_UPDATE;
				end
			end
			mer_pkg::ST_UPDATE: begin
				if (phase_q == mer_pkg::PH_R2 && sts.y_neg) begin
					// Ellipse already finished: drop the step
					phase_d = mer_pkg::PH_IDLE;
					state_d = mer_pkg::ST_READY;
				end else begin
					if (phase_q == mer_pkg::PH_R2 && sts.y_zero) begin
						phase_d = mer_pkg::PH_IDLE;
					end
					state_d = mer_pkg::ST_EMIT;
					cnt_d   = '0;
				end
			end
			mer_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					if (cnt_q == mer_pkg::CNT_W'(mer_pkg::EMIT_LAST)) begin
						state_d = mer_pkg::ST_READY;
					end else begin
						cnt_d = cnt_q + 1'b1;
					end
				end
			end
			default: begin
				state_d = mer_pkg::ST_READY;
			end
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd      = '0;
		in_ready = (state_q == mer_pkg::ST_READY);
		unique case (state_q)
			mer_pkg::ST_READY: begin
				cmd.load_start = accept && (in_op == mer_pkg::OP_START);
			end
			mer_pkg::ST_START: begin
				case (cnt_q)
					3'd0: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = mer_pkg::MS_AA;
					end
					3'd1: begin
						cmd.ld_a2   = 1'b1;
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = mer_pkg::MS_BB;
					end
					3'd2: begin
						cmd.ld_b2   = 1'b1;
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = mer_pkg::MS_A2Y;
					end
					default: begin
						cmd.init_fin = 1'b1;
					end
				endcase
			end
			mer_pkg::ST_XOVER: begin
				case (cnt_q)
					3'd0: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = mer_pkg::MS_TT;
					end
					3'd1: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = mer_pkg::MS_B2P;
					end
					3'd2: begin
						cmd.acc_ld  = 1'b1;
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = mer_pkg::MS_UU;
					end
					3'd3: begin
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = mer_pkg::MS_A2P;
					end
					3'd4: begin
						cmd.acc_add = 1'b1;
						cmd.mul_en  = 1'b1;
						cmd.mul_sel = mer_pkg::MS_A2B2;
					end
					default: begin
						cmd.xover_fin = 1'b1;
					end
				endcase
			end
			mer_pkg::ST_UPDATE: begin
				cmd.update  = !(phase_q == mer_pkg::PH_R2 && sts.y_neg);
				cmd.region2 = (phase_q == mer_pkg::PH_R2);
				cmd.done    = (phase_q == mer_pkg::PH_R2) && sts.y_zero;
			end
			mer_pkg::ST_EMIT: begin
				cmd.emit_ld  = sts.out_free;
				cmd.emit_idx = cnt_q[1:0];
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: rtl/core/mer_dp.sv
// Datapath of the midpoint ellipse rasterizer: position, decision, shared multiplier, point register.
module mer_dp #(
	parameter int SCREEN_W  = mer_pkg::SCREEN_W_DEF,
	parameter int SCREEN_H  = mer_pkg::SCREEN_H_DEF,
	parameter int AXIS_BITS = mer_pkg::AXIS_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic signed [mer_pkg::CENTER_W-1:0] center_x,
	input  logic signed [mer_pkg::CENTER_W-1:0] center_y,
	input  logic [mer_pkg::AXIS_W-1:0]          axis_x,
	input  logic [mer_pkg::AXIS_W-1:0]          axis_y,
	input  mer_pkg::dp_cmd_t                    cmd,
	output mer_pkg::dp_sts_t                    sts,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [mer_pkg::PIX_W-1:0]    pixel_x,
	output logic signed [mer_pkg::PIX_W-1:0]    pixel_y,
	output logic                                last_of_step,
	output logic                                ellipse_done
);

	// Effective semi-axis width and derived datapath widths
	localparam int AW = (AXIS_BITS < mer_pkg::AXIS_W) ? AXIS_BITS : mer_pkg::AXIS_W;
	localparam int XW = AW + 1;
	localparam int YW = AW + 2;
	localparam int MW = 2 * AW + 4;
	localparam int DW = 2 * MW;
	localparam int SW = 3 * AW + 3;
	localparam int EW = ((AW + 2 > 12) ? AW + 2 : 12) + 2;
	localparam int HX = SCREEN_W / 2;
	localparam int HY = SCREEN_H / 2;

	logic signed [mer_pkg::CENTER_W-1:0] cx_q, cy_q;
	logic [AW-1:0]          a_q;
	logic [2*AW-1:0]        a2_q, b2_q;
	logic [XW-1:0]          pos_x_q, nx;
	logic signed [YW-1:0]   pos_y_q, ny;
	logic signed [SW-1:0]   dx_q, dy_q, ndx, ndy;
	logic signed [DW-1:0]   dec_q, ndec, acc_q;
	logic [DW-1:0]          prod_q;
	logic [XW-1:0]          snap_x_q;
	logic signed [YW-1:0]   snap_y_q;
	logic                   snap_done_q;
	logic                   out_valid_q;
	logic signed [mer_pkg::PIX_W-1:0] pixel_x_q, pixel_y_q;
	logic                   last_q, done_q;

	logic [MW-1:0]          op_a, op_b, y_op;
	logic [YW-1:0]          t_val, u_mag;
	logic signed [YW-1:0]   u_val;
	logic signed [DW-1:0]   prod_s, a2_e, b2_e, dxi_e, dyd_e;
	logic signed [SW-1:0]   b2x2, a2x2, dx_inc, dy_dec;
	logic signed [EW-1:0]   hx_e, hy_e, cx_e, cy_e, x_e, y_e, px, py;

	// Extend squares and products into the decision width
	assign prod_s = signed'(prod_q);
	assign a2_e   = signed'({{(DW-2*AW){1'b0}}, a2_q});
	assign b2_e   = signed'({{(DW-2*AW){1'b0}}, b2_q});
	assign b2x2   = signed'({{(SW-2*AW-1){1'b0}}, b2_q, 1'b0});
	assign a2x2   = signed'({{(SW-2*AW-1){1'b0}}, a2_q, 1'b0});
	assign dx_inc = dx_q + b2x2;
	assign dy_dec = dy_q - a2x2;
	assign dxi_e  = DW'(dx_inc);
	assign dyd_e  = DW'(dy_dec);

	// Crossover terms 2x+1 and |y-1|
	assign t_val = {pos_x_q, 1'b1};
	assign u_val = pos_y_q - 1'b1;
	assign u_mag = u_val[YW-1] ? $unsigned(-u_val) : $unsigned(u_val);
	assign y_op  = MW'($unsigned(pos_y_q));

	// Select multiplier operands
	always_comb begin
		unique case (cmd.mul_sel)
			mer_pkg::MS_AA: begin
				op_a = MW'(a_q);
				op_b = MW'(a_q);
			end
			mer_pkg::MS_BB: begin
				op_a = y_op;
				op_b = y_op;
			end
			mer_pkg::MS_A2Y: begin
				op_a = MW'(a2_q);
				op_b = y_op;
			end
			mer_pkg::MS_TT: begin
				op_a = MW'(t_val);
				op_b = MW'(t_val);
			end
			mer_pkg::MS_B2P: begin
				op_a = MW'(b2_q);
				op_b = prod_q[MW-1:0];
			end
			mer_pkg::MS_UU: begin
				op_a = MW'(u_mag);
				op_b = MW'(u_mag);
			end
			mer_pkg::MS_A2P: begin
				op_a = MW'(a2_q);
				op_b = prod_q[MW-1:0];
			end
			mer_pkg::MS_A2B2: begin
				op_a = MW'(a2_q);
				op_b = MW'(b2_q);
			end
		endcase
	end

	// Register the product
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= op_a * op_b;
		end
	end

	// Advance one point in region 1 or region 2
	always_comb begin
		nx   = pos_x_q;
		ny   = pos_y_q;
		ndx  = dx_q;
		ndy  = dy_q;
		ndec = dec_q;
		if (!cmd.region2) begin
			nx  = pos_x_q + 1'b1;
			ndx = dx_inc;
			if (dec_q[DW-1]) begin
				ndec = dec_q + ((dxi_e + b2_e) <<< 2);
			end else begin
				ny   = pos_y_q - 1'b1;
				ndy  = dy_dec;
				ndec = dec_q + ((dxi_e - dyd_e + b2_e) <<< 2);
			end
		end else begin
			ny  = pos_y_q - 1'b1;
			ndy = dy_dec;
			if (!dec_q[DW-1] && (dec_q != '0)) begin
				ndec = dec_q + ((a2_e - dyd_e) <<< 2);
			end else begin
				nx   = pos_x_q + 1'b1;
				ndx  = dx_inc;
				ndec = dec_q + ((dxi_e - dyd_e + a2_e) <<< 2);
			end
		end
	end

	// Hold ellipse state
	always_ff @(posedge clk) begin
		if (cmd.load_start) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			a_q     <= axis_x[AW-1:0];
			pos_x_q <= '0;
			pos_y_q <= signed'({2'b00, axis_y[AW-1:0]});
			dx_q    <= '0;
		end else if (cmd.update) begin
			pos_x_q <= nx;
			pos_y_q <= ny;
			dx_q    <= ndx;
		end
		if (cmd.ld_a2) begin
			a2_q <= prod_q[2*AW-1:0];
		end
		if (cmd.ld_b2) begin
			b2_q <= prod_q[2*AW-1:0];
		end
		if (cmd.init_fin) begin
			dy_q  <= signed'({prod_q[SW-2:0], 1'b0});
			dec_q <= (b2_e <<< 2) - (prod_s <<< 2) + a2_e;
		end else if (cmd.xover_fin) begin
			dec_q <= acc_q - (prod_s <<< 2);
		end else if (cmd.update) begin
			dy_q  <= ndy;
			dec_q <= ndec;
		end
		if (cmd.acc_ld) begin
			acc_q <= prod_s;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + (prod_s <<< 2);
		end
		if (cmd.update) begin
			snap_x_q    <= pos_x_q;
			snap_y_q    <= pos_y_q;
			snap_done_q <= cmd.done;
		end
	end

	// Map the snapped position to screen coordinates; idx bit 0 mirrors x, bit 1 mirrors y
	assign hx_e = EW'(HX);
	assign hy_e = EW'(HY);
	assign cx_e = EW'(cx_q);
	assign cy_e = EW'(cy_q);
	assign x_e  = signed'(EW'(snap_x_q));
	assign y_e  = EW'(snap_y_q);
	assign px   = hx_e + cx_e + (cmd.emit_idx[0] ? -x_e : x_e);
	assign py   = hy_e - (cy_e + (cmd.emit_idx[1] ? -y_e : y_e));

	// Point output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_ld) begin
			pixel_x_q <= px[mer_pkg::PIX_W-1:0];
			pixel_y_q <= py[mer_pkg::PIX_W-1:0];
			last_q    <= (cmd.emit_idx == 2'(mer_pkg::EMIT_LAST));
			done_q    <= snap_done_q;
		end
	end

	// Status back to the controller
	assign sts.dx_lt_dy = (dx_q < dy_q);
	assign sts.y_zero   = (pos_y_q == '0);
	assign sts.y_neg    = pos_y_q[YW-1];
	assign sts.out_free = !out_valid_q || out_ready;

	assign out_valid    = out_valid_q;
	assign pixel_x      = pixel_x_q;
	assign pixel_y      = pixel_y_q;
	assign last_of_step = last_q;
	assign ellipse_done = done_q;

endmodule
